@@ rtl/tvr_pkg.sv @@
// Package: shared types, register indexes and sizing constants for the resampler.
`timescale 1ns / 1ps
package tvr_pkg;

  localparam int TVR_MAX_DIM    = 64;
  localparam int TVR_VOXEL_BITS = 16;

  localparam int IDX_W   = 18;
  localparam int VAL_W   = 16;
  localparam int CRD_W   = 10;
  localparam int DIMC_W  = 7;
  localparam int STEP_W  = 22;
  localparam int CFGI_W  = 3;
  localparam int CFGD_W  = 22;
  localparam int POS_W   = CRD_W + STEP_W;
  localparam int WGT_W   = 17;

  localparam logic [CFGI_W-1:0] REG_DIM_X  = 3'd0;
  localparam logic [CFGI_W-1:0] REG_DIM_Y  = 3'd1;
  localparam logic [CFGI_W-1:0] REG_DIM_Z  = 3'd2;
  localparam logic [CFGI_W-1:0] REG_STEP_X = 3'd3;
  localparam logic [CFGI_W-1:0] REG_STEP_Y = 3'd4;
  localparam logic [CFGI_W-1:0] REG_STEP_Z = 3'd5;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  voxel_index;
    logic [VAL_W-1:0]  voxel_value;
    logic [CRD_W-1:0]  cx;
    logic [CRD_W-1:0]  cy;
    logic [CRD_W-1:0]  cz;
  } tvr_req_t;

  typedef struct packed {
    logic [DIMC_W-1:0] dim_x;
    logic [DIMC_W-1:0] dim_y;
    logic [DIMC_W-1:0] dim_z;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
    logic [STEP_W-1:0] step_z;
  } tvr_cfg_t;

endpackage

@@ rtl/tvr_front.sv @@
// Front end: accepts requests and queues them for the back end.
`timescale 1ns / 1ps
module tvr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tvr_pkg::tvr_req_t    in_req,
  output logic                 q_valid,
  output tvr_pkg::tvr_req_t    q_req,
  input  logic                 q_pop
);
  import tvr_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  tvr_req_t          fifo_r [DEPTH];
  logic [PW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]       cnt_r, cnt_nxt;
  logic              push, pop;

  assign in_stall = (cnt_r == (PW+1)'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_req    = fifo_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= in_req;
    end
  end

endmodule

@@ rtl/tvr_ram.sv @@
// Voxel RAM copy: one write port, one registered read port.
`timescale 1ns / 1ps
module tvr_ram #(
  parameter int AW = 18,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/tvr_back.sv @@
// Back end: voxel load writes, position mapping, corner fetch and trilinear blend pipeline.
`timescale 1ns / 1ps
module tvr_back #(
  parameter int MAX_DIM    = tvr_pkg::TVR_MAX_DIM,
  parameter int VOXEL_BITS = tvr_pkg::TVR_VOXEL_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tvr_pkg::tvr_cfg_t            cfg,
  input  logic                         q_valid,
  input  tvr_pkg::tvr_req_t            q_req,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tvr_pkg::VAL_W-1:0]    out_sample_value,
  output logic                         out_position_clamped
);
  import tvr_pkg::*;

  localparam int VB    = VOXEL_BITS;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int IW    = $clog2(MAX_DIM);
  localparam int AW    = 3 * IW;
  localparam int SW    = 2 * DW + IW + 2;
  localparam longint DEPTH = longint'(MAX_DIM) ** 3;

  function automatic logic [DW-1:0] eff_dim(input logic [DIMC_W-1:0] d);
    logic [DW-1:0] r;
    begin
      if (d == '0) r = DW'(1);
      else if (32'(d) > 32'(MAX_DIM)) r = DW'(MAX_DIM);
      else r = DW'(d);
      return r;
    end
  endfunction

  typedef struct packed {
    logic [IW-1:0]    i1;
    logic [IW-1:0]    i2;
    logic [WGT_W-1:0] t;
    logic             clamp;
  } axis_t;

  function automatic axis_t axis_map(input logic [POS_W-1:0] p_in,
                                     input logic [DW-1:0] dim);
    logic [POS_W-1:0] last, p, hi_q;
    logic [DW-1:0]    i1e, lim;
    axis_t            a;
    begin
      lim  = dim - 1'b1;
      last = POS_W'(lim) << 16;
      p    = p_in;
      a.clamp = 1'b0;
      if (p > last) begin
        p = last;
        a.clamp = 1'b1;
      end
      a.i1 = IW'(p >> 16);
      i1e  = DW'(a.i1) + 1'b1;
      a.i2 = (i1e > lim) ? IW'(lim) : IW'(i1e);
      hi_q = POS_W'(a.i2) << 16;
      a.t  = WGT_W'(hi_q - p);
      return a;
    end
  endfunction

  function automatic logic [VB-1:0] blend(input logic [VB-1:0] lo,
                                          input logic [VB-1:0] hi,
                                          input logic [WGT_W-1:0] t);
    logic [VB+WGT_W:0] s;
    begin
      s = (VB+WGT_W+1)'(hi) * (VB+WGT_W+1)'(17'h10000 - t)
        + (VB+WGT_W+1)'(lo) * (VB+WGT_W+1)'(t);
      return VB'(s >> 16);
    end
  endfunction

  logic en;
  logic [DW-1:0]   dx_r, dy_r, dz_r;
  logic [2*DW-1:0] dxy_r;

  logic             s1_v_r, s1_smp_r, s1_ok_r;
  logic [AW-1:0]    s1_idx_r;
  logic [VB-1:0]    s1_val_r;
  logic [POS_W-1:0] s1_px_r, s1_py_r, s1_pz_r;

  logic             s2_v_r, s2_smp_r, s2_ok_r;
  logic [AW-1:0]    s2_idx_r;
  logic [VB-1:0]    s2_val_r;
  axis_t            s2_ax_r, s2_ay_r, s2_az_r;

  logic             s3_v_r, s3_smp_r, s3_ok_r;
  logic [AW-1:0]    s3_idx_r;
  logic [VB-1:0]    s3_val_r;
  logic [IW-1:0]    s3_x1_r, s3_x2_r;
  logic [SW-1:0]    s3_y1_r, s3_y2_r, s3_z1_r, s3_z2_r;
  logic [WGT_W-1:0] s3_tx_r, s3_ty_r, s3_tz_r;
  logic             s3_cl_r;

  logic             s4_v_r, s4_smp_r, s4_cl_r;
  logic [WGT_W-1:0] s4_tx_r, s4_ty_r, s4_tz_r;
  logic [VB-1:0]    rd [8];
  logic [AW-1:0]    raddr [8];
  logic             ram_we;

  logic             s5_v_r, s5_smp_r, s5_cl_r;
  logic [WGT_W-1:0] s5_ty_r, s5_tz_r;
  logic [VB-1:0]    s5_b_r [4];

  logic             s6_v_r, s6_smp_r, s6_cl_r;
  logic [WGT_W-1:0] s6_tz_r;
  logic [VB-1:0]    s6_b_r [2];

  logic             out_v_r;
  logic [VAL_W-1:0] out_val_r;
  logic             out_cl_r;

  assign en    = !out_v_r || !out_stall;
  assign q_pop = en;

  always_ff @(posedge clk) begin
    dx_r  <= eff_dim(cfg.dim_x);
    dy_r  <= eff_dim(cfg.dim_y);
    dz_r  <= eff_dim(cfg.dim_z);
    dxy_r <= (2*DW)'(dx_r) * (2*DW)'(dy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= q_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      out_v_r <= s6_v_r && s6_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_smp_r <= (q_req.req_type == REQ_SAMPLE);
      s1_ok_r  <= 64'(q_req.voxel_index) < 64'(DEPTH);
      s1_idx_r <= AW'(q_req.voxel_index);
      s1_val_r <= VB'(q_req.voxel_value);
      s1_px_r  <= POS_W'(q_req.cx) * POS_W'(cfg.step_x);
      s1_py_r  <= POS_W'(q_req.cy) * POS_W'(cfg.step_y);
      s1_pz_r  <= POS_W'(q_req.cz) * POS_W'(cfg.step_z);

      s2_smp_r <= s1_smp_r;
      s2_ok_r  <= s1_ok_r;
      s2_idx_r <= s1_idx_r;
      s2_val_r <= s1_val_r;
      s2_ax_r  <= axis_map(s1_px_r, dx_r);
      s2_ay_r  <= axis_map(s1_py_r, dy_r);
      s2_az_r  <= axis_map(s1_pz_r, dz_r);

      s3_smp_r <= s2_smp_r;
      s3_ok_r  <= s2_ok_r;
      s3_idx_r <= s2_idx_r;
      s3_val_r <= s2_val_r;
      s3_x1_r  <= s2_ax_r.i1;
      s3_x2_r  <= s2_ax_r.i2;
      s3_y1_r  <= SW'(s2_ay_r.i1) * SW'(dx_r);
      s3_y2_r  <= SW'(s2_ay_r.i2) * SW'(dx_r);
      s3_z1_r  <= SW'(s2_az_r.i1) * SW'(dxy_r);
      s3_z2_r  <= SW'(s2_az_r.i2) * SW'(dxy_r);
      s3_tx_r  <= s2_ax_r.t;
      s3_ty_r  <= s2_ay_r.t;
      s3_tz_r  <= s2_az_r.t;
      s3_cl_r  <= s2_ax_r.clamp | s2_ay_r.clamp | s2_az_r.clamp;

      s4_smp_r <= s3_smp_r;
      s4_cl_r  <= s3_cl_r;
      s4_tx_r  <= s3_tx_r;
      s4_ty_r  <= s3_ty_r;
      s4_tz_r  <= s3_tz_r;

      s5_smp_r  <= s4_smp_r;
      s5_cl_r   <= s4_cl_r;
      s5_ty_r   <= s4_ty_r;
      s5_tz_r   <= s4_tz_r;
      s5_b_r[0] <= blend(rd[0], rd[1], s4_tx_r);
      s5_b_r[1] <= blend(rd[2], rd[3], s4_tx_r);
      s5_b_r[2] <= blend(rd[4], rd[5], s4_tx_r);
      s5_b_r[3] <= blend(rd[6], rd[7], s4_tx_r);

      s6_smp_r  <= s5_smp_r;
      s6_cl_r   <= s5_cl_r;
      s6_tz_r   <= s5_tz_r;
      s6_b_r[0] <= blend(s5_b_r[0], s5_b_r[1], s5_ty_r);
      s6_b_r[1] <= blend(s5_b_r[2], s5_b_r[3], s5_ty_r);

      out_val_r <= VAL_W'(blend(s6_b_r[0], s6_b_r[1], s6_tz_r));
      out_cl_r  <= s6_cl_r;
    end
  end

  assign ram_we = s3_v_r && !s3_smp_r && s3_ok_r;

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      raddr[c] = AW'(SW'(c[0] ? s3_x2_r : s3_x1_r)
                   + (c[1] ? s3_y2_r : s3_y1_r)
                   + (c[2] ? s3_z2_r : s3_z1_r));
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_bank
    tvr_ram #(.AW(AW), .DW(VB)) u_ram (
      .clk   (clk),
      .en    (en),
      .we    (ram_we),
      .waddr (s3_idx_r),
      .wdata (s3_val_r),
      .raddr (raddr[g]),
      .rdata (rd[g])
    );
  end

  assign out_valid            = out_v_r;
  assign out_sample_value     = out_val_r;
  assign out_position_clamped = out_cl_r;

endmodule

@@ rtl/trilinear_volume_resampler_top.sv @@
// Top level: configuration registers, front queue and resampling back end.
//
//  channel  ports                                   handshake
//  request  in_req_type .. in_out_z                 in_valid / in_stall
//  result   out_sample_value, out_position_clamped  out_valid / out_stall
//  config   cfg_index, cfg_data                     cfg_we
//
// One request per cycle sustained while out_stall is low; a sample's result passes through
// one queue slot, six map/fetch/blend stages and the output register.
// Eight voxel RAM copies give all eight corner reads of a sample in the same cycle.
// Reset clears queue and pipeline valids; voxel contents stay undefined.
// out_stall freezes the back end while a result is held; the four-entry queue keeps accepting until full.
`timescale 1ns / 1ps
module trilinear_volume_resampler_top #(
  parameter int MAX_DIM    = tvr_pkg::TVR_MAX_DIM,
  parameter int VOXEL_BITS = tvr_pkg::TVR_VOXEL_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [tvr_pkg::IDX_W-1:0]     in_voxel_index,
  input  logic [tvr_pkg::VAL_W-1:0]     in_voxel_value,
  input  logic [tvr_pkg::CRD_W-1:0]     in_out_x,
  input  logic [tvr_pkg::CRD_W-1:0]     in_out_y,
  input  logic [tvr_pkg::CRD_W-1:0]     in_out_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tvr_pkg::VAL_W-1:0]     out_sample_value,
  output logic                          out_position_clamped,
  input  logic                          cfg_we,
  input  logic [tvr_pkg::CFGI_W-1:0]    cfg_index,
  input  logic [tvr_pkg::CFGD_W-1:0]    cfg_data
);
  import tvr_pkg::*;

  tvr_cfg_t cfg_r;
  tvr_req_t in_req, q_req;
  logic     q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dim_x  <= DIMC_W'(64);
      cfg_r.dim_y  <= DIMC_W'(64);
      cfg_r.dim_z  <= DIMC_W'(64);
      cfg_r.step_x <= STEP_W'(65536);
      cfg_r.step_y <= STEP_W'(65536);
      cfg_r.step_z <= STEP_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIM_X:  cfg_r.dim_x  <= cfg_data[DIMC_W-1:0];
        REG_DIM_Y:  cfg_r.dim_y  <= cfg_data[DIMC_W-1:0];
        REG_DIM_Z:  cfg_r.dim_z  <= cfg_data[DIMC_W-1:0];
        REG_STEP_X: cfg_r.step_x <= cfg_data[STEP_W-1:0];
        REG_STEP_Y: cfg_r.step_y <= cfg_data[STEP_W-1:0];
        REG_STEP_Z: cfg_r.step_z <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_req.req_type    = in_req_type;
    in_req.voxel_index = in_voxel_index;
    in_req.voxel_value = in_voxel_value;
    in_req.cx          = in_out_x;
    in_req.cy          = in_out_y;
    in_req.cz          = in_out_z;
  end

  tvr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .q_pop    (q_pop)
  );

  tvr_back #(.MAX_DIM(MAX_DIM), .VOXEL_BITS(VOXEL_BITS)) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_valid              (q_valid),
    .q_req                (q_req),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_sample_value     (out_sample_value),
    .out_position_clamped (out_position_clamped)
  );

endmodule
